### rtl/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 128;
	localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// Op queue between front and back; depth must be a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CHAR_W = 8;
	typedef logic [CHAR_W-1:0] char_t;

	localparam char_t CH_NUL    = 8'h00;
	localparam char_t CH_LROUND = 8'h28; // (
	localparam char_t CH_RROUND = 8'h29; // )
	localparam char_t CH_LSQUARE = 8'h5b; // [
	localparam char_t CH_RSQUARE = 8'h5d; // ]
	localparam char_t CH_LCURLY = 8'h7b; // {
	localparam char_t CH_RCURLY = 8'h7d; // }

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_ROUND  = 2'd0;
	localparam kind_t KIND_SQUARE = 2'd1;
	localparam kind_t KIND_CURLY  = 2'd2;

	typedef enum logic [1:0] {
		OP_OPEN,
		OP_CLOSE,
		OP_END
	} op_code_t;

	typedef struct packed {
		op_code_t code;
		kind_t    kind;
	} op_t;

	// Front -> queue
	typedef struct packed {
		logic valid;
		op_t  op;
	} q_push_t;

	// Queue -> back
	typedef struct packed {
		logic valid;
		op_t  op;
	} q_head_t;

	// Back -> top, for checking
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               err;
		logic               end_taken;
	} back_status_t;

endpackage

`default_nettype wire

### rtl/bbc_if.sv
`default_nettype none

interface bbc_char_if import bbc_pkg::*; ();
	logic  valid;
	logic  ready;
	char_t character;

	modport source (output valid, output character, input ready);
	modport sink   (input valid, input character, output ready);
endinterface

interface bbc_verdict_if import bbc_pkg::*; ();
	logic valid;
	logic ready;
	logic balanced;

	modport source (output valid, output balanced, input ready);
	modport sink   (input valid, input balanced, output ready);
endinterface

`default_nettype wire

### rtl/bbc_ram.sv
`default_nettype none

module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/bbc_front.sv
`default_nettype none

module bbc_front import bbc_pkg::*; (
	bbc_char_if.sink chars,
	input  logic     q_full,
	output q_push_t  push
);

	op_t  op;
	logic keep;

	always_comb begin
		op   = '{code: OP_END, kind: KIND_ROUND};
		keep = 1'b1;
		unique case (chars.character)
			CH_NUL:     op = '{code: OP_END,   kind: KIND_ROUND};
			CH_LROUND:  op = '{code: OP_OPEN,  kind: KIND_ROUND};
			CH_LSQUARE: op = '{code: OP_OPEN,  kind: KIND_SQUARE};
			CH_LCURLY:  op = '{code: OP_OPEN,  kind: KIND_CURLY};
			CH_RROUND:  op = '{code: OP_CLOSE, kind: KIND_ROUND};
			CH_RSQUARE: op = '{code: OP_CLOSE, kind: KIND_SQUARE};
			CH_RCURLY:  op = '{code: OP_CLOSE, kind: KIND_CURLY};
			default:    keep = 1'b0; // plain text, dropped here
		endcase
	end

	assign chars.ready = !q_full;
	assign push.valid  = chars.valid && !q_full && keep;
	assign push.op     = op;

endmodule

`default_nettype wire

### rtl/bbc_queue.sv
`default_nettype none

module bbc_queue import bbc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_push_t push,
	output logic    full,
	output q_head_t head,
	input  logic    pop
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.op    = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

endmodule

`default_nettype wire

### rtl/bbc_back.sv
`default_nettype none

module bbc_back import bbc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  q_head_t              head,
	output logic                 pop,
	bbc_verdict_if.source        verdict,
	output back_status_t         status
);

	// top of stack lives in top_q; RAM holds entries below it
	logic [LEVEL_W-1:0] level_q;
	logic               err_q;
	kind_t              top_q;
	logic               fwd_q;
	kind_t              fwd_data_q;
	logic               out_valid_q;
	logic               balanced_q;

	logic [LEVEL_W-1:0] level_d;
	logic               err_d;
	kind_t              top_d;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [ADDR_W-1:0]  raddr;
	kind_t              rdata;
	kind_t              below;
	logic               end_take;

	assign below    = fwd_q ? fwd_data_q : rdata;
	assign pop      = head.valid &&
	                  (head.op.code != OP_END || !out_valid_q || verdict.ready);
	assign end_take = pop && head.op.code == OP_END;
	assign waddr    = ADDR_W'(level_q - LEVEL_W'(1));
	assign raddr    = ADDR_W'(level_d - LEVEL_W'(2));

	always_comb begin
		level_d = level_q;
		err_d   = err_q;
		top_d   = top_q;
		we      = 1'b0;
		if (pop) begin
			unique case (head.op.code)
				OP_OPEN: begin
					if (level_q < LEVEL_W'(STACK_DEPTH)) begin
						we      = (level_q != '0);
						top_d   = head.op.kind;
						level_d = level_q + LEVEL_W'(1);
					end else begin
						err_d = 1'b1;
					end
				end
				OP_CLOSE: begin
					if (level_q != '0 && top_q == head.op.kind) begin
						top_d   = below;
						level_d = level_q - LEVEL_W'(1);
					end else begin
						err_d = 1'b1;
					end
				end
				OP_END: begin
					level_d = '0;
					err_d   = 1'b0;
				end
				default: ;
			endcase
		end
	end

	bbc_ram #(
		.WIDTH ($bits(kind_t)),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (top_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			err_q       <= 1'b0;
			fwd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			level_q <= level_d;
			err_q   <= err_d;
			fwd_q   <= we;
			if (end_take) begin
				out_valid_q <= 1'b1;
			end else if (verdict.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q      <= top_d;
		fwd_data_q <= top_q;
		if (end_take) begin
			balanced_q <= !err_q && (level_q == '0);
		end
	end

	assign verdict.valid    = out_valid_q;
	assign verdict.balanced = balanced_q;

	assign status.level     = level_q;
	assign status.err       = err_q;
	assign status.end_taken = end_take;

endmodule

`default_nettype wire

### rtl/bracket_balance_checker.sv
// A zero byte passes the op queue; the back end taking it sets the registered verdict valid.
// Throughput: one character per cycle unless a pending verdict stalls; the back end does one
//   push or pop per cycle, with the top entry in a register and the RAM read one level ahead.
// Reset (arst_n low, asynchronous): stack level, error flag, op queue and output
//   register are cleared; the stack RAM is not cleared and is never read unwritten.
`default_nettype none

module bracket_balance_checker import bbc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bbc_char_if.sink      chars,
	bbc_verdict_if.source verdict
);

	// Front: classifies each byte into open/close/end, drops everything else.
	// Queue: two-entry op buffer so front and back stall independently.
	// Back: stack with top-of-stack register, RAM below it, sticky error,
	//       registered verdict output.

	q_push_t      push;
	q_head_t      head;
	logic         q_full;
	logic         q_pop;
	back_status_t status;

	bbc_front u_front (
		.chars  (chars),
		.q_full (q_full),
		.push   (push)
	);

	bbc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (q_pop)
	);

	bbc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (q_pop),
		.verdict (verdict),
		.status  (status)
	);

	// Stack never holds more than its depth
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.level <= LEVEL_W'(STACK_DEPTH))
		else $error("stack level beyond depth");

	// End of string wipes the state for the next one
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		status.end_taken |=> (status.level == '0) && !status.err)
		else $error("state not cleared after end of string");

	// Every end of string gives a verdict transaction
	a_end_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		status.end_taken |=> verdict.valid)
		else $error("end of string without verdict");

endmodule

`default_nettype wire

### dv/tb_bracket_balance_checker.sv
module tb_bracket_balance_checker;
	timeunit 1ns;
	timeprecision 1ps;

	import bbc_pkg::*;

	// Scoreboard: tracks the open-bracket stack of the string in flight and
	// queues one expected verdict per terminating zero byte.
	class verdict_scoreboard;
		kind_t       open_kinds[STACK_DEPTH];
		int unsigned depth_used;
		bit          mismatch_seen;
		bit          expected_verdicts[$];
		int unsigned fail_count;

		task report_mismatch(input string msg);
			$display("[%0t] verdict mismatch: %s", $time, msg);
			fail_count++;
		endtask

		// Called on every accepted character; returns 1 if the byte acts on the state
		function bit note_char(input char_t c);
			kind_t k = KIND_ROUND;
			bit    opening = 1'b0;
			case (c)
				CH_NUL: begin
					expected_verdicts.push_back(!mismatch_seen && depth_used == 0);
					depth_used    = 0;
					mismatch_seen = 1'b0;
					return 1'b1;
				end
				CH_LROUND:  begin opening = 1'b1; k = KIND_ROUND;  end
				CH_LSQUARE: begin opening = 1'b1; k = KIND_SQUARE; end
				CH_LCURLY:  begin opening = 1'b1; k = KIND_CURLY;  end
				CH_RROUND:  k = KIND_ROUND;
				CH_RSQUARE: k = KIND_SQUARE;
				CH_RCURLY:  k = KIND_CURLY;
				default: return 1'b0;
			endcase
			if (opening) begin
				if (depth_used < STACK_DEPTH) begin
					open_kinds[depth_used] = k;
					depth_used++;
				end else
					mismatch_seen = 1'b1;
			end else if (depth_used == 0 || open_kinds[depth_used-1] != k)
				mismatch_seen = 1'b1;
			else
				depth_used--;
			return 1'b1;
		endfunction

		task check_verdict(input logic balanced);
			bit want;
			if (expected_verdicts.size() == 0) begin
				report_mismatch($sformatf("balanced=%b with no string pending", balanced));
				return;
			end
			want = expected_verdicts.pop_front();
			if (balanced !== want)
				report_mismatch($sformatf("balanced=%b, expected %b", balanced, want));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bbc_char_if    chars_if ();
	bbc_verdict_if verdict_if ();

	bracket_balance_checker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.verdict (verdict_if)
	);

	verdict_scoreboard sb = new();

	// Idle percentages, changed between phases of the random run
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned sent_bytes    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop, well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic char_t open_char(input kind_t k);
		case (k)
			KIND_ROUND:  return CH_LROUND;
			KIND_SQUARE: return CH_LSQUARE;
			default:     return CH_LCURLY;
		endcase
	endfunction

	function automatic char_t close_char(input kind_t k);
		case (k)
			KIND_ROUND:  return CH_RROUND;
			KIND_SQUARE: return CH_RSQUARE;
			default:     return CH_RCURLY;
		endcase
	endfunction

	function automatic bit is_bracket(input char_t c);
		case (c)
			CH_LROUND, CH_RROUND, CH_LSQUARE, CH_RSQUARE, CH_LCURLY, CH_RCURLY:
				return 1'b1;
			default:
				return 1'b0;
		endcase
	endfunction

	// Builds one zero-terminated string. Most are properly nested with filler
	// between brackets; some get a single flaw; a few are pure noise. Deep
	// strings run the stack up to, and just past, its full depth.
	function automatic void make_string(output char_t s[$], input bit deep);
		kind_t pend[$];
		kind_t k;
		char_t f;
		int    n;
		int    r;
		s = {};
		if (deep) begin
			repeat ($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2)) begin
				k = kind_t'($urandom_range(0, 2));
				pend.push_back(k);
				s.push_back(open_char(k));
			end
			// opens beyond the full depth are never stored
			while (pend.size() > STACK_DEPTH)
				void'(pend.pop_back());
			n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
			while (pend.size() > n)
				s.push_back(close_char(pend.pop_back()));
			s.push_back(CH_NUL);
			return;
		end
		repeat ($urandom_range(0, 20)) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				k = kind_t'($urandom_range(0, 2));
				pend.push_back(k);
				s.push_back(open_char(k));
			end else if (r < 80 && pend.size() > 0)
				s.push_back(close_char(pend.pop_back()));
			else begin
				do
					f = char_t'($urandom_range(1, 255));
				while (is_bracket(f));
				s.push_back(f);
			end
		end
		while (pend.size() > 0)
			s.push_back(close_char(pend.pop_back()));
		case ($urandom_range(0, 7))
			0: if (s.size() > 0)
				s.delete($urandom_range(0, s.size() - 1));
			1: s.insert($urandom_range(0, s.size()), close_char(kind_t'($urandom_range(0, 2))));
			2: if (s.size() > 0) begin
				k = kind_t'($urandom_range(0, 2));
				s[$urandom_range(0, s.size() - 1)] =
					$urandom_range(0, 1) ? open_char(k) : close_char(k);
			end
			3: begin
				s = {};
				repeat ($urandom_range(1, 12))
					s.push_back(char_t'($urandom_range(1, 255)));
			end
			default: ;
		endcase
		s.push_back(CH_NUL);
	endfunction

	// Offers one character and holds it until the transaction completes.
	// Entered and left just after a rising edge. Ready is sampled at the
	// falling edge, where it has settled for the coming rising edge.
	task send_char(input char_t c);
		bit took;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.character <= c;
		do begin
			@(negedge clk);
			took = chars_if.ready;
			@(posedge clk);
		end while (!took);
		void'(sb.note_char(c));
		sent_bytes++;
	endtask

	task send_bytes(input char_t s[$]);
		foreach (s[i])
			send_char(s[i]);
	endtask

	// Verdict side: random back-pressure; a transaction seen at the falling
	// edge completes at the following rising edge.
	initial begin
		bit   fire;
		logic bal;
		verdict_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			fire = arst_n && verdict_if.valid && verdict_if.ready;
			bal  = verdict_if.balanced;
			@(posedge clk);
			if (fire)
				sb.check_verdict(bal);
			verdict_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		// Directed strings: empty string, every bracket kind, close on an empty
		// stack, wrong close followed by further pops, unclosed open, and the
		// field extremes as ignored filler.
		char_t directed[$] = '{
			CH_NUL,
			CH_LROUND, CH_RROUND, CH_LSQUARE, CH_RSQUARE, CH_LCURLY, CH_RCURLY, CH_NUL,
			CH_RROUND, CH_NUL,
			CH_LROUND, CH_RSQUARE, CH_RROUND, CH_NUL,
			CH_LCURLY, CH_NUL,
			8'hff, 8'h01, 8'h80, CH_NUL
		};
		char_t       str[$];
		int unsigned str_count;
		int unsigned target;
		int unsigned guard;

		arst_n             <= 1'b0;
		chars_if.valid     <= 1'b0;
		chars_if.character <= CH_NUL;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_bytes(directed);

		// Three random phases: sender lightly idle with heavy back-pressure,
		// then the reverse, then full rate on both sides.
		str_count = 0;
		target    = sent_bytes;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin send_idle_pct = 13; recv_idle_pct = 58; end
				1:       begin send_idle_pct = 58; recv_idle_pct = 13; end
				default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
			endcase
			target += 545;
			while (sent_bytes < target) begin
				// every fortieth string, starting with the first, fills the stack
				make_string(str, (str_count % 40) == 0);
				send_bytes(str);
				str_count++;
			end
		end
		chars_if.valid <= 1'b0;

		// Drain outstanding verdicts, then give the pipeline time to show any
		// spurious extra transaction.
		guard = 0;
		while (sb.expected_verdicts.size() != 0 && guard < 50_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (sb.expected_verdicts.size() != 0)
			sb.report_mismatch($sformatf("%0d verdicts never arrived",
				sb.expected_verdicts.size()));

		if (sb.fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/bbc_pkg.sv
rtl/bbc_if.sv
rtl/bbc_ram.sv
rtl/bbc_front.sv
rtl/bbc_queue.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker.sv
dv/tb_bracket_balance_checker.sv
